### hdl/b2da_pkg.sv
// Shared constants for the binary to decimal ASCII converter.
// No dependencies.
`default_nettype none
package b2da_pkg;
   localparam int VALUE_BITS     = 64;
   localparam int MAX_DIGITS     = 20;
   localparam int BCD_BITS       = 4 * MAX_DIGITS;
   localparam int BIT_CNT_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DIGIT_CNT_BITS = $clog2(MAX_DIGITS + 1);
   localparam logic [5:0] ASCII_ZERO = 6'd48;
   localparam logic [5:0] ASCII_NINE = 6'd57;
   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;
endpackage : b2da_pkg
`default_nettype wire

### hdl/b2da_dabble_step.sv
// One shift-add-3 step of the double dabble conversion over the whole digit register.
// Depends on b2da_pkg.
`default_nettype none
module b2da_dabble_step (
   input  wire logic [b2da_pkg::BCD_BITS-1:0] bcd,
   input  wire logic                          bit_in,
   output logic [b2da_pkg::BCD_BITS-1:0]      bcd_next
);
   logic [b2da_pkg::BCD_BITS-1:0] adjusted;

   always_comb begin
      for (int d = 0; d < b2da_pkg::MAX_DIGITS; d++) begin
         if (bcd[4*d +: 4] >= b2da_pkg::BCD_ADJ_LIMIT) begin
            adjusted[4*d +: 4] = bcd[4*d +: 4] + b2da_pkg::BCD_ADJ_ADD;
         end else begin
            adjusted[4*d +: 4] = bcd[4*d +: 4];
         end
      end
   end

   // top digit's carry is dropped: register holds the value mod 10^MAX_DIGITS
   assign bcd_next = {adjusted[b2da_pkg::BCD_BITS-2:0], bit_in};
endmodule : b2da_dabble_step
`default_nettype wire

### hdl/binary_to_decimal_ascii_unit.sv
// Binary to decimal ASCII converter, top level: sequencer and output register.
// Depends on b2da_pkg and b2da_dabble_step.
//
// One request carries an unsigned 64-bit value; the unit answers with its
// decimal digits as ASCII characters, most significant first, no leading
// zeros, a zero value giving a single '0'. rsp_last_digit marks the final
// character. Conversion runs one input bit per cycle through a shared
// shift-add-3 step, then leading zeros are stripped one digit per cycle and
// digits are sent one per cycle while rsp_ready is high. Each request passes
// through the idle state, the conversion, the zero skip and the digit output;
// req_ready is high only when the unit is idle, so a new request is accepted
// only after the last digit of the previous one is taken.
`default_nettype none
module binary_to_decimal_ascii_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_number_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_digit_char,
   output logic             rsp_last_digit
);
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type                              state_ff, state_in;
   logic [b2da_pkg::VALUE_BITS-1:0]        value_ff, value_in;
   logic [b2da_pkg::BCD_BITS-1:0]          bcd_ff, bcd_in;
   logic [b2da_pkg::BIT_CNT_BITS-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [b2da_pkg::DIGIT_CNT_BITS-1:0]    digits_left_ff, digits_left_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [5:0]                             rsp_digit_char_ff, rsp_digit_char_in;
   logic                                   rsp_last_digit_ff, rsp_last_digit_in;
   logic [b2da_pkg::BCD_BITS-1:0]          bcd_step;
   logic [3:0]                             top_digit;
   logic [b2da_pkg::BCD_BITS-1:0]          bcd_shifted;
   logic                                   on_last;

   b2da_dabble_step u_step (
      .bcd      (bcd_ff),
      .bit_in   (value_ff[b2da_pkg::VALUE_BITS-1]),
      .bcd_next (bcd_step)
   );

   assign top_digit   = bcd_ff[b2da_pkg::BCD_BITS-1 -: 4];
   assign bcd_shifted = {bcd_ff[b2da_pkg::BCD_BITS-5:0], 4'd0};
   assign on_last     = (digits_left_ff == b2da_pkg::DIGIT_CNT_BITS'(1));

   always_comb begin
      state_in          = state_ff;
      value_in          = value_ff;
      bcd_in            = bcd_ff;
      bit_cnt_in        = bit_cnt_ff;
      digits_left_in    = digits_left_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_digit_char_in = rsp_digit_char_ff;
      rsp_last_digit_in = rsp_last_digit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in   = req_number_in[b2da_pkg::VALUE_BITS-1:0];
               bcd_in     = '0;
               bit_cnt_in = b2da_pkg::BIT_CNT_BITS'(b2da_pkg::VALUE_BITS - 1);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in     = bcd_step;
            value_in   = {value_ff[b2da_pkg::VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               digits_left_in = b2da_pkg::DIGIT_CNT_BITS'(b2da_pkg::MAX_DIGITS);
               state_in       = ST_SKIP;
            end
         end
         ST_SKIP: begin
            bcd_in         = bcd_shifted;
            digits_left_in = digits_left_ff - 1'b1;
            if ((top_digit != 4'd0) || on_last) begin
               rsp_valid_in      = 1'b1;
               rsp_digit_char_in = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
               rsp_last_digit_in = on_last;
               state_in          = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (rsp_last_digit_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_digit_char_in = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
                  rsp_last_digit_in = on_last;
                  bcd_in            = bcd_shifted;
                  digits_left_in    = digits_left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff          <= value_in;
      bcd_ff            <= bcd_in;
      bit_cnt_ff        <= bit_cnt_in;
      digits_left_ff    <= digits_left_in;
      rsp_digit_char_ff <= rsp_digit_char_in;
      rsp_last_digit_ff <= rsp_last_digit_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_digit_char_ff;
   assign rsp_last_digit = rsp_last_digit_ff;

`ifndef ASSERT_OFF
   a_valid_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_EMIT))
      else $error("response valid outside emit state");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid_ff))
      else $error("request taken while response pending");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_digit_char_ff >= b2da_pkg::ASCII_ZERO &&
                        rsp_digit_char_ff <= b2da_pkg::ASCII_NINE))
      else $error("digit character out of range");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && rsp_last_digit_ff) |=> (state_ff == ST_IDLE))
      else $error("run did not end after last digit");

   a_last_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_digit_ff == (digits_left_ff == '0)))
      else $error("last flag disagrees with digit count");
`endif
endmodule : binary_to_decimal_ascii_unit
`default_nettype wire
